/* hw/rtl/rspr_pkg.sv */
// Shared types, character codes and result kinds for the remote-protocol
// packet receiver. Used by rspr_skid and rsp_packet_receiver; depends on nothing.
`default_nettype none

package rspr_pkg;

   // Result kinds carried on rsp_tuser
   localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
   localparam logic [2:0] KIND_GOOD      = 3'd1;
   localparam logic [2:0] KIND_MISMATCH  = 3'd2;
   localparam logic [2:0] KIND_INTERRUPT = 3'd3;
   localparam logic [2:0] KIND_OVERLONG  = 3'd4;
   localparam logic [2:0] KIND_TIMEOUT   = 3'd5;

   // Input beat kinds carried on req_tuser
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Framing characters and acknowledge bytes
   localparam logic [7:0] CH_START = 8'h24;  // '$'
   localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
   localparam logic [7:0] CH_BREAK = 8'h03;  // interrupt request
   localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'
   localparam logic [7:0] CH_NAK   = 8'h2D;  // '-'
   localparam logic [7:0] CH_NONE  = 8'h00;

   localparam logic [7:0] TIMEOUT_RESET = 8'd10;
   localparam int LEN_W = 11;

   typedef struct packed {
      logic [2:0]       kind;
      logic [7:0]       payload_byte;
      logic [7:0]       reply_byte;
      logic [LEN_W-1:0] payload_length;
      logic [7:0]       computed_sum;
      logic [7:0]       received_sum;
   } result_type;

   typedef struct packed {
      logic       bad;
      logic [3:0] value;
   } hex_type;

   // Decode one ASCII hex digit; anything else flags bad and decodes as zero
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.bad   = 1'b0;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         h.value = c[3:0] + 4'd9;
      end else begin
         h.bad = 1'b1;
      end
      return h;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/rsp_packet_receiver.sv */
// Top level of the remote-protocol packet receiver: framing state machine,
// checksum and timeout logic. Uses rspr_pkg and rspr_skid.
`default_nettype none

// Takes one serial byte or idle tick per cycle on req_* while req_tready is
// high, and reports payload bytes, packet status and interrupts on rsp_*. Each
// beat is handled combinationally (an 8-bit add, the payload count compare and
// a hex decode), so a beat may be accepted every cycle; its result is
// registered in a two-entry output buffer, so input continues while a result
// is stalled; req_tready drops only when both entries are full. Between
// packets, ticks and bytes other than break give no result, nor do the start
// character, the hash or the high checksum digit. csr_* sets the idle tick
// timeout (reset 10) and should be written only while no packet is open.
module rsp_packet_receiver #(
   parameter int MAX_PAYLOAD = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input beats
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_value
   input  wire logic        req_tuser,   // [0] op (0 byte, 1 idle tick)
   // result beats
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [7:0] payload_byte, [15:8] reply_byte,
                                         // [26:16] payload_length,
                                         // [34:27] computed_sum,
                                         // [42:35] received_sum, [47:43] zero
   output logic [2:0]       rsp_tuser,   // [2:0] kind
   // timeout register write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data     // timeout_ticks
);

   localparam int CW = $clog2(MAX_PAYLOAD + 1);
   localparam logic [CW-1:0] LAST_COUNT = CW'(MAX_PAYLOAD - 1);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DATA,
      PH_HI,
      PH_LO
   } phase_type;

   phase_type      phase_ff, phase_in;
   logic [7:0]     sum_ff, sum_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [3:0]     high_ff, high_in;
   logic           derr_ff, derr_in;
   logic [7:0]     idle_ff, idle_in;
   logic [7:0]     timeout_ff;

   logic                 accept;
   logic                 res_valid;
   rspr_pkg::result_type res;
   rspr_pkg::result_type out_res;
   rspr_pkg::hex_type    hex;
   logic [7:0]           sum_next;
   logic [CW-1:0]        count_next;
   logic [CW+10:0]       count_ext;
   logic [CW+10:0]       next_ext;
   logic [7:0]           rsum;
   logic                 good;

   assign accept    = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign hex        = rspr_pkg::hex_decode(req_tdata);
   assign sum_next   = sum_ff + req_tdata;
   assign count_next = count_ff + CW'(1);
   assign count_ext  = {{rspr_pkg::LEN_W{1'b0}}, count_ff};
   assign next_ext   = {{rspr_pkg::LEN_W{1'b0}}, count_next};
   assign rsum       = {high_ff, hex.value};
   assign good       = !derr_ff && !hex.bad && (rsum == sum_ff);

   // Advance the framing state for one accepted beat and form its result
   always_comb begin
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      high_in   = high_ff;
      derr_in   = derr_ff;
      idle_in   = idle_ff;
      res_valid = 1'b0;
      res       = '0;
      if (accept) begin
         if (req_tuser == rspr_pkg::OP_TICK) begin
            if (phase_ff != PH_IDLE) begin
               if (idle_ff >= timeout_ff) begin
                  res_valid          = 1'b1;
                  res.kind           = rspr_pkg::KIND_TIMEOUT;
                  res.reply_byte     = rspr_pkg::CH_NAK;
                  res.payload_length = count_ext[rspr_pkg::LEN_W-1:0];
                  res.computed_sum   = sum_ff;
                  phase_in = PH_IDLE;
                  sum_in   = '0;
                  count_in = '0;
                  high_in  = '0;
                  derr_in  = 1'b0;
                  idle_in  = '0;
               end else begin
                  idle_in = idle_ff + 8'd1;
               end
            end
         end else begin
            idle_in = '0;
            unique case (phase_ff)
               PH_IDLE: begin
                  if (req_tdata == rspr_pkg::CH_BREAK) begin
                     res_valid      = 1'b1;
                     res.kind       = rspr_pkg::KIND_INTERRUPT;
                     res.reply_byte = rspr_pkg::CH_ACK;
                  end else if (req_tdata == rspr_pkg::CH_START) begin
                     phase_in = PH_DATA;
                     sum_in   = '0;
                     count_in = '0;
                     high_in  = '0;
                     derr_in  = 1'b0;
                  end
               end
               PH_DATA: begin
                  if (req_tdata == rspr_pkg::CH_HASH) begin
                     phase_in = PH_HI;
                  end else begin
                     res_valid          = 1'b1;
                     res.payload_length = next_ext[rspr_pkg::LEN_W-1:0];
                     res.computed_sum   = sum_next;
                     if (count_ff == LAST_COUNT) begin
                        // drop the packet: too long
                        res.kind       = rspr_pkg::KIND_OVERLONG;
                        res.reply_byte = rspr_pkg::CH_NAK;
                        phase_in = PH_IDLE;
                        sum_in   = '0;
                        count_in = '0;
                        high_in  = '0;
                        derr_in  = 1'b0;
                     end else begin
                        res.kind         = rspr_pkg::KIND_PAYLOAD;
                        res.payload_byte = req_tdata;
                        res.reply_byte   = rspr_pkg::CH_NONE;
                        sum_in   = sum_next;
                        count_in = count_next;
                     end
                  end
               end
               PH_HI: begin
                  high_in  = hex.value;
                  derr_in  = hex.bad;
                  phase_in = PH_LO;
               end
               PH_LO: begin
                  res_valid          = 1'b1;
                  res.kind           = good ? rspr_pkg::KIND_GOOD : rspr_pkg::KIND_MISMATCH;
                  res.reply_byte     = good ? rspr_pkg::CH_ACK : rspr_pkg::CH_NAK;
                  res.payload_length = count_ext[rspr_pkg::LEN_W-1:0];
                  res.computed_sum   = sum_ff;
                  res.received_sum   = rsum;
                  phase_in = PH_IDLE;
                  sum_in   = '0;
                  count_in = '0;
                  high_in  = '0;
                  derr_in  = 1'b0;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // Hold framing state and the timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         sum_ff     <= '0;
         count_ff   <= '0;
         high_ff    <= '0;
         derr_ff    <= 1'b0;
         idle_ff    <= '0;
         timeout_ff <= rspr_pkg::TIMEOUT_RESET;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         high_ff  <= high_in;
         derr_ff  <= derr_in;
         idle_ff  <= idle_in;
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_data;
         end
      end
   end

   // Buffer results toward the output side
   rspr_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (req_tready),
      .in_data   (res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_res)
   );

   assign rsp_tuser = out_res.kind;
   assign rsp_tdata = {5'd0, out_res.received_sum, out_res.computed_sum,
                       out_res.payload_length, out_res.reply_byte,
                       out_res.payload_byte};

   // Input stalls only while a result is already waiting
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // Between packets the running sum, count and idle tick count stay cleared
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> (count_ff == '0 && sum_ff == '0 && idle_ff == '0))
      else $error("packet state not cleared while idle");

   // The payload count never goes past MAX_PAYLOAD - 1
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_COUNT)
      else $error("payload count past limit");

   // A tick between packets never produces a result
   a_tick_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == rspr_pkg::OP_TICK && phase_ff == PH_IDLE) |-> !res_valid)
      else $error("result from an idle tick outside a packet");

endmodule

`default_nettype wire

/* hw/rtl/rspr_skid.sv */
// Two-entry output buffer for result beats: an output register plus a skid
// register, so the receiver keeps taking beats while a result waits. Uses rspr_pkg.
`default_nettype none

module rspr_skid (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire rspr_pkg::result_type in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output rspr_pkg::result_type      out_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   rspr_pkg::result_type main_ff, main_in;
   rspr_pkg::result_type skid_ff, skid_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Pop the output slot first, then place a new beat in the first free slot
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_valid_ff && out_ready) begin
         main_valid_in = skid_valid_ff;
         main_in       = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (in_valid && !skid_valid_ff) begin
         if (!main_valid_in) begin
            main_valid_in = 1'b1;
            main_in       = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = in_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire
